// ===== rtl/core/prq_pkg.sv =====
// ----------------------------------------------------------------------------
// prq_pkg: shared types and codes of the priority ready-queue scheduler
// Holds the request and response structs, the sizes and the mode and switch codes.
// ----------------------------------------------------------------------------
package prq_pkg;

   localparam int PRIORITY_LEVELS = 32;
   localparam int THREAD_SLOTS    = 32;

   localparam logic [1:0] MODE_INSERT   = 2'd0;
   localparam logic [1:0] MODE_REMOVE   = 2'd1;
   localparam logic [1:0] MODE_SCHEDULE = 2'd2;
   localparam logic [1:0] MODE_START    = 2'd3;

   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_TASK  = 2'd1;
   localparam logic [1:0] KIND_IRQ   = 2'd2;
   localparam logic [1:0] KIND_FIRST = 2'd3;

   typedef struct packed {
      logic [1:0] mode;
      logic [4:0] thread_id;
      logic [4:0] priority_req;
      logic       sched_locked;
      logic       in_interrupt;
   } req_type;

   typedef struct packed {
      logic [1:0]  switch_kind;
      logic        from_valid;
      logic [4:0]  prev_thread;
      logic [4:0]  next_thread;
      logic [4:0]  running_priority;
      logic        none_ready;
      logic [31:0] ready_bits;
   } rsp_type;

endpackage

// ===== rtl/core/priority_ready_queue_scheduler.sv =====
// ----------------------------------------------------------------------------
// priority_ready_queue_scheduler: ready-queue scheduler with priority bitmap
// Per-priority FIFOs as doubly linked lists in RAM, head/tail per priority.
// ----------------------------------------------------------------------------
// The response strobe is registered from the write-back state, which follows
// the read state. No new request is taken while busy; busy covers the
// list-end read state (after the thread links arrive) and write-back state.
// Reset clears the bitmap, the queued bits and the running thread; the link
// RAMs are not cleared. The receiver cannot stall the response strobe.
module priority_ready_queue_scheduler
   import prq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_READ  = 2'd1;
   localparam logic [1:0] ST_WRITE = 2'd2;

   logic [1:0]  state_ff, state_in;
   req_type     req_ff;
   logic [31:0] mask_ff, mask_in;
   logic [4:0]  run_thread_ff, run_thread_in;
   logic        run_valid_ff, run_valid_in;
   logic [4:0]  run_prio_ff, run_prio_in;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff, rsp_in;
   logic [4:0]  sel_prio_ff, sel_prio_in;
   logic        sel_found_ff, sel_found_in;

   // queued bits live in flip-flops so reset clears them at once
   logic [THREAD_SLOTS-1:0] queued_ff, queued_in;

   // per-thread RAMs: next link, prev link, queued priority
   logic       nx_we, pv_we, pr_we;
   logic [4:0] nx_waddr, pv_waddr, pr_waddr, link_raddr;
   logic [4:0] nx_wdata, pv_wdata, pr_wdata;
   logic [4:0] nx_rdata, pv_rdata, pr_rdata;
   // per-priority RAM: {head, tail}
   logic       end_we;
   logic [4:0] end_waddr, end_raddr;
   logic [9:0] end_wdata, end_rdata;
   logic [4:0] hd_rdata, tl_rdata;

   prq_ram #(.WIDTH(5), .DEPTH(THREAD_SLOTS)) u_nxram (
      .clock(clock), .wr_en(nx_we), .wr_addr(nx_waddr), .wr_data(nx_wdata),
      .rd_addr(link_raddr), .rd_data(nx_rdata));
   prq_ram #(.WIDTH(5), .DEPTH(THREAD_SLOTS)) u_pvram (
      .clock(clock), .wr_en(pv_we), .wr_addr(pv_waddr), .wr_data(pv_wdata),
      .rd_addr(link_raddr), .rd_data(pv_rdata));
   prq_ram #(.WIDTH(5), .DEPTH(THREAD_SLOTS)) u_prram (
      .clock(clock), .wr_en(pr_we), .wr_addr(pr_waddr), .wr_data(pr_wdata),
      .rd_addr(link_raddr), .rd_data(pr_rdata));
   prq_ram #(.WIDTH(10), .DEPTH(PRIORITY_LEVELS)) u_endram (
      .clock(clock), .wr_en(end_we), .wr_addr(end_waddr), .wr_data(end_wdata),
      .rd_addr(end_raddr), .rd_data(end_rdata));

   logic [4:0] tid;
   logic [4:0] rq_prio;
   logic       ins_ok, rem_ok;
   logic       accept;
   logic [4:0] ffs;
   logic       ffs_found;

   assign accept   = start && !busy;
   assign tid      = req_ff.thread_id;
   assign rq_prio  = req_ff.priority_req;
   assign ins_ok   = (req_ff.mode == MODE_INSERT) && !queued_ff[tid];
   assign rem_ok   = (req_ff.mode == MODE_REMOVE) && queued_ff[tid];
   assign hd_rdata = end_rdata[9:5];
   assign tl_rdata = end_rdata[4:0];

   // read the thread links at acceptance, then hold the same entry;
   // requests never overlap, so every read sees the last write-back
   assign link_raddr = (state_ff == ST_IDLE) ? req_data.thread_id : tid;

   // find the lowest set ready bit
   always_comb begin
      ffs = '0;
      ffs_found = 1'b0;
      for (int i = 31; i >= 0; i--) begin
         if (mask_ff[i]) begin
            ffs = 5'(i);
            ffs_found = 1'b1;
         end
      end
   end

   // pick the priority whose list ends are needed
   always_comb begin
      sel_prio_in  = sel_prio_ff;
      sel_found_in = sel_found_ff;
      if (state_ff == ST_READ) begin
         sel_found_in = 1'b1;
         case (req_ff.mode)
            MODE_INSERT: sel_prio_in = rq_prio;
            MODE_REMOVE: sel_prio_in = pr_rdata;
            default: begin
               sel_prio_in  = ffs;
               sel_found_in = ffs_found;
            end
         endcase
      end
   end

   assign end_raddr = sel_prio_in;

   // modify and write back
   always_comb begin
      state_in      = state_ff;
      mask_in       = mask_ff;
      queued_in     = queued_ff;
      run_thread_in = run_thread_ff;
      run_valid_in  = run_valid_ff;
      run_prio_in   = run_prio_ff;
      rsp_in        = rsp_ff;
      nx_we = 1'b0;  nx_waddr = tid;  nx_wdata = tid;
      pv_we = 1'b0;  pv_waddr = tid;  pv_wdata = tid;
      pr_we = 1'b0;  pr_waddr = tid;  pr_wdata = rq_prio;
      end_we = 1'b0; end_waddr = sel_prio_ff; end_wdata = end_rdata;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_WRITE;
            // a new thread ends its list: next points to itself
            nx_we = ins_ok;
         end
         ST_WRITE: begin
            state_in = ST_IDLE;
            rsp_in.switch_kind = KIND_NONE;
            rsp_in.from_valid  = 1'b0;
            rsp_in.prev_thread = '0;
            rsp_in.none_ready  = 1'b0;
            case (req_ff.mode)
               MODE_INSERT: begin
                  if (ins_ok) begin
                     if (!mask_ff[rq_prio]) begin
                        end_wdata = {tid, tid};
                     end else begin
                        // link old tail forward to the new thread
                        nx_we    = 1'b1;
                        nx_waddr = tl_rdata;
                        nx_wdata = tid;
                        pv_wdata = tl_rdata;
                        end_wdata = {hd_rdata, tid};
                     end
                     end_we = 1'b1;
                     pv_we  = 1'b1;
                     pr_we  = 1'b1;
                     queued_in[tid] = 1'b1;
                     mask_in[rq_prio] = 1'b1;
                  end
               end
               MODE_REMOVE: begin
                  if (rem_ok) begin
                     queued_in[tid] = 1'b0;
                     if (hd_rdata == tid && tl_rdata == tid) begin
                        mask_in[sel_prio_ff] = 1'b0;
                     end else if (hd_rdata == tid) begin
                        end_we    = 1'b1;
                        end_wdata = {nx_rdata, tl_rdata};
                     end else if (tl_rdata == tid) begin
                        end_we    = 1'b1;
                        end_wdata = {hd_rdata, pv_rdata};
                     end else begin
                        // splice the neighbors together
                        nx_we    = 1'b1;
                        nx_waddr = pv_rdata;
                        nx_wdata = nx_rdata;
                        pv_we    = 1'b1;
                        pv_waddr = nx_rdata;
                        pv_wdata = pv_rdata;
                     end
                  end
               end
               MODE_SCHEDULE: begin
                  if (!req_ff.sched_locked) begin
                     if (!sel_found_ff) begin
                        rsp_in.none_ready = 1'b1;
                     end else if (!run_valid_ff || hd_rdata != run_thread_ff) begin
                        rsp_in.from_valid  = run_valid_ff;
                        rsp_in.prev_thread = run_valid_ff ? run_thread_ff : 5'd0;
                        run_prio_in   = sel_prio_ff;
                        run_thread_in = hd_rdata;
                        run_valid_in  = 1'b1;
                        rsp_in.switch_kind = req_ff.in_interrupt ? KIND_IRQ : KIND_TASK;
                     end
                  end
               end
               default: begin
                  if (!sel_found_ff) begin
                     rsp_in.none_ready = 1'b1;
                  end else begin
                     run_thread_in = hd_rdata;
                     run_valid_in  = 1'b1;
                     rsp_in.switch_kind = KIND_FIRST;
                  end
               end
            endcase
            rsp_in.next_thread      = run_thread_in;
            rsp_in.running_priority = run_prio_in;
            rsp_in.ready_bits       = mask_in;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         mask_ff       <= '0;
         queued_ff     <= '0;
         run_thread_ff <= '0;
         run_valid_ff  <= 1'b0;
         run_prio_ff   <= 5'(PRIORITY_LEVELS - 1);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mask_ff       <= mask_in;
         queued_ff     <= queued_in;
         run_thread_ff <= run_thread_in;
         run_valid_ff  <= run_valid_in;
         run_prio_ff   <= run_prio_in;
         rsp_valid_ff  <= (state_ff == ST_WRITE);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) req_ff <= req_data;
      sel_prio_ff  <= sel_prio_in;
      sel_found_ff <= sel_found_in;
      rsp_ff       <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // one request at a time: read, write back, then idle
   a_busy_seq: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy ##1 busy ##1 !busy);

   // one response strobe after the read and write-back states of each request
   a_rsp_lat: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##3 rsp_valid);

   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid);

   // reported bitmap is the stored one
   a_bits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.ready_bits == mask_ff));

endmodule

// ===== rtl/core/prq_ram.sv =====
// ----------------------------------------------------------------------------
// prq_ram: generic single-port-write, one-read memory
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module prq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== tb/priority_ready_queue_scheduler_test.sv =====
// ----------------------------------------------------------------------------
// priority_ready_queue_scheduler_test: self-checking bench for the scheduler
// Drives a directed table of requests and then random requests, with the
// sender idling in several phases. Every response is compared field by field
// with a typed row response or a built-in model of per-priority ready FIFOs.
// ----------------------------------------------------------------------------
module priority_ready_queue_scheduler_test
   import prq_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LEVELS = PRIORITY_LEVELS;
   localparam int SLOTS  = THREAD_SLOTS;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   priority_ready_queue_scheduler dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data)
   );

   // scheduler model state
   logic [31:0] mdl_ready;
   logic [4:0]  mdl_head [LEVELS];
   logic [4:0]  mdl_tail [LEVELS];
   logic [4:0]  mdl_next [SLOTS];
   logic [4:0]  mdl_prev [SLOTS];
   logic        mdl_queued [SLOTS];
   logic [4:0]  mdl_qprio [SLOTS];
   logic [4:0]  mdl_run;
   logic        mdl_run_valid;
   logic [4:0]  mdl_run_prio;

   rsp_type pending_rsp[$];
   int      fail_count;
   int      idle_pct;

   typedef struct {
      req_type req;
      logic    known;
      rsp_type rsp;
   } row_type;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic req_type make_req(logic [1:0] m, logic [4:0] t, logic [4:0] p,
                                        logic l, logic i);
      req_type r;
      r.mode = m;
      r.thread_id = t;
      r.priority_req = p;
      r.sched_locked = l;
      r.in_interrupt = i;
      return r;
   endfunction

   function automatic rsp_type make_rsp(logic [1:0] k, logic fv, logic [4:0] ft,
                                        logic [4:0] tt, logic [4:0] rp, logic nr,
                                        logic [31:0] rb);
      rsp_type r;
      r.switch_kind = k;
      r.from_valid = fv;
      r.prev_thread = ft;
      r.next_thread = tt;
      r.running_priority = rp;
      r.none_ready = nr;
      r.ready_bits = rb;
      return r;
   endfunction

   task automatic clear_model();
      mdl_ready = '0;
      mdl_run = '0;
      mdl_run_valid = 1'b0;
      mdl_run_prio = 5'(LEVELS - 1);
      for (int i = 0; i < SLOTS; i++) begin
         mdl_queued[i] = 1'b0;
         mdl_qprio[i] = '0;
         mdl_next[i] = '0;
         mdl_prev[i] = '0;
      end
      for (int i = 0; i < LEVELS; i++) begin
         mdl_head[i] = '0;
         mdl_tail[i] = '0;
      end
   endtask

   function automatic int lowest_ready_level();
      for (int p = 0; p < LEVELS; p++)
         if (mdl_ready[p]) return p;
      return -1;
   endfunction

   // advance the model by one request and return the response it gives
   function automatic rsp_type schedule_step(req_type r);
      rsp_type o;
      int p;
      logic [4:0] t, nx, pv, q;
      o = make_rsp(KIND_NONE, 1'b0, '0, mdl_run, '0, 1'b0, '0);
      t = r.thread_id;
      case (r.mode)
         MODE_INSERT: begin
            q = r.priority_req;
            if (!mdl_queued[t]) begin
               if (!mdl_ready[q]) begin
                  mdl_head[q] = t;
                  mdl_prev[t] = t;
               end else begin
                  mdl_next[mdl_tail[q]] = t;
                  mdl_prev[t] = mdl_tail[q];
               end
               mdl_next[t] = t;
               mdl_tail[q] = t;
               mdl_ready[q] = 1'b1;
               mdl_queued[t] = 1'b1;
               mdl_qprio[t] = q;
            end
         end
         MODE_REMOVE: begin
            if (mdl_queued[t]) begin
               q = mdl_qprio[t];
               nx = mdl_next[t];
               pv = mdl_prev[t];
               if (mdl_head[q] == t && mdl_tail[q] == t) mdl_ready[q] = 1'b0;
               else if (mdl_head[q] == t) mdl_head[q] = nx;
               else if (mdl_tail[q] == t) mdl_tail[q] = pv;
               else begin
                  mdl_next[pv] = nx;
                  mdl_prev[nx] = pv;
               end
               mdl_queued[t] = 1'b0;
            end
         end
         MODE_SCHEDULE: begin
            if (!r.sched_locked) begin
               p = lowest_ready_level();
               if (p < 0) o.none_ready = 1'b1;
               else begin
                  o.next_thread = mdl_head[p];
                  if (!mdl_run_valid || mdl_head[p] != mdl_run) begin
                     o.from_valid = mdl_run_valid;
                     o.prev_thread = mdl_run_valid ? mdl_run : 5'd0;
                     mdl_run_prio = 5'(p);
                     mdl_run = mdl_head[p];
                     mdl_run_valid = 1'b1;
                     o.switch_kind = r.in_interrupt ? KIND_IRQ : KIND_TASK;
                  end
               end
            end
         end
         default: begin
            p = lowest_ready_level();
            if (p < 0) o.none_ready = 1'b1;
            else begin
               o.next_thread = mdl_head[p];
               mdl_run = mdl_head[p];
               mdl_run_valid = 1'b1;
               o.switch_kind = KIND_FIRST;
            end
         end
      endcase
      o.running_priority = mdl_run_prio;
      o.ready_bits = mdl_ready;
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   // check each response strobe against the oldest expectation
   always @(posedge clock) begin
      rsp_type w;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected response", 32'd1, 32'd0);
         end else begin
            w = pending_rsp.pop_front();
            if (rsp_data.switch_kind != w.switch_kind)
               report_mismatch("switch_kind", 32'(rsp_data.switch_kind),
                               32'(w.switch_kind));
            if (rsp_data.from_valid != w.from_valid)
               report_mismatch("from_valid", 32'(rsp_data.from_valid),
                               32'(w.from_valid));
            if (rsp_data.prev_thread != w.prev_thread)
               report_mismatch("prev_thread", 32'(rsp_data.prev_thread),
                               32'(w.prev_thread));
            if (rsp_data.next_thread != w.next_thread)
               report_mismatch("next_thread", 32'(rsp_data.next_thread),
                               32'(w.next_thread));
            if (rsp_data.running_priority != w.running_priority)
               report_mismatch("running_priority", 32'(rsp_data.running_priority),
                               32'(w.running_priority));
            if (rsp_data.none_ready != w.none_ready)
               report_mismatch("none_ready", 32'(rsp_data.none_ready),
                               32'(w.none_ready));
            if (rsp_data.ready_bits != w.ready_bits)
               report_mismatch("ready_bits", rsp_data.ready_bits, w.ready_bits);
         end
      end
   end

   // hold the request until accepted; a typed row's response overrides the model
   task automatic send_request(req_type r, logic known, rsp_type k);
      rsp_type e;
      while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      e = schedule_step(r);
      pending_rsp.push_back(known ? k : e);
   endtask

   function automatic req_type random_request(int phase);
      int sel;
      logic [4:0] tid;
      sel = $urandom_range(99);
      // small thread sets in early phases and a small level set in phase 1 keep FIFOs deep
      tid = (phase < 2) ? 5'($urandom_range(7)) : 5'($urandom);
      if (sel < 40)
         return make_req(MODE_INSERT, tid,
                         (phase == 1) ? 5'($urandom_range(3)) : 5'($urandom),
                         1'($urandom), 1'($urandom));
      else if (sel < 70)
         return make_req(MODE_REMOVE, tid, 5'($urandom), 1'($urandom), 1'($urandom));
      else if (sel < 93)
         return make_req(MODE_SCHEDULE, 5'($urandom), 5'($urandom),
                         ($urandom_range(3) == 0), 1'($urandom));
      return make_req(MODE_START, 5'($urandom), 5'($urandom), 1'($urandom),
                      1'($urandom));
   endfunction

   initial begin
      row_type rows[$];
      rsp_type unused;
      int waited;
      unused = '0;
      fail_count = 0;
      idle_pct = 0;
      clear_model();
      reset <= 1'b1;
      start <= 1'b0;
      req_data <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed table: after reset and at the extremes, some rows with typed responses
      rows.push_back('{make_req(MODE_SCHEDULE, 5'd0, 5'd0, 1'b0, 1'b0), 1'b1,
                       make_rsp(KIND_NONE, 1'b0, 5'd0, 5'd0, 5'd31, 1'b1, 32'h0)});
      rows.push_back('{make_req(MODE_START, 5'd31, 5'd31, 1'b1, 1'b1), 1'b1,
                       make_rsp(KIND_NONE, 1'b0, 5'd0, 5'd0, 5'd31, 1'b1, 32'h0)});
      rows.push_back('{make_req(MODE_SCHEDULE, 5'd0, 5'd0, 1'b1, 1'b0), 1'b1,
                       make_rsp(KIND_NONE, 1'b0, 5'd0, 5'd0, 5'd31, 1'b0, 32'h0)});
      rows.push_back('{make_req(MODE_REMOVE, 5'd5, 5'd0, 1'b0, 1'b0), 1'b1,
                       make_rsp(KIND_NONE, 1'b0, 5'd0, 5'd0, 5'd31, 1'b0, 32'h0)});
      rows.push_back('{make_req(MODE_INSERT, 5'd31, 5'd31, 1'b0, 1'b0), 1'b1,
                       make_rsp(KIND_NONE, 1'b0, 5'd0, 5'd0, 5'd31, 1'b0, 32'h80000000)});
      rows.push_back('{make_req(MODE_INSERT, 5'd31, 5'd0, 1'b0, 1'b0), 1'b0, unused});
      rows.push_back('{make_req(MODE_SCHEDULE, 5'd0, 5'd0, 1'b0, 1'b0), 1'b1,
                       make_rsp(KIND_TASK, 1'b0, 5'd0, 5'd31, 5'd31, 1'b0, 32'h80000000)});
      rows.push_back('{make_req(MODE_INSERT, 5'd0, 5'd0, 1'b0, 1'b0), 1'b1,
                       make_rsp(KIND_NONE, 1'b0, 5'd0, 5'd31, 5'd31, 1'b0, 32'h80000001)});
      rows.push_back('{make_req(MODE_INSERT, 5'd1, 5'd0, 1'b1, 1'b1), 1'b0, unused});
      rows.push_back('{make_req(MODE_INSERT, 5'd2, 5'd0, 1'b0, 1'b0), 1'b0, unused});
      rows.push_back('{make_req(MODE_INSERT, 5'd3, 5'd0, 1'b0, 1'b0), 1'b0, unused});
      rows.push_back('{make_req(MODE_SCHEDULE, 5'd0, 5'd0, 1'b0, 1'b1), 1'b1,
                       make_rsp(KIND_IRQ, 1'b1, 5'd31, 5'd0, 5'd0, 1'b0, 32'h80000001)});
      rows.push_back('{make_req(MODE_SCHEDULE, 5'd0, 5'd0, 1'b0, 1'b0), 1'b0, unused});
      rows.push_back('{make_req(MODE_REMOVE, 5'd2, 5'd0, 1'b0, 1'b0), 1'b0, unused});
      rows.push_back('{make_req(MODE_REMOVE, 5'd3, 5'd0, 1'b0, 1'b0), 1'b0, unused});
      rows.push_back('{make_req(MODE_REMOVE, 5'd0, 5'd31, 1'b0, 1'b0), 1'b0, unused});
      rows.push_back('{make_req(MODE_START, 5'd0, 5'd0, 1'b0, 1'b0), 1'b0, unused});
      rows.push_back('{make_req(MODE_SCHEDULE, 5'd0, 5'd0, 1'b0, 1'b0), 1'b0, unused});
      rows.push_back('{make_req(MODE_REMOVE, 5'd1, 5'd0, 1'b0, 1'b0), 1'b0, unused});
      rows.push_back('{make_req(MODE_REMOVE, 5'd31, 5'd0, 1'b0, 1'b0), 1'b0, unused});
      rows.push_back('{make_req(MODE_START, 5'd0, 5'd0, 1'b0, 1'b0), 1'b0, unused});
      foreach (rows[i]) send_request(rows[i].req, rows[i].known, rows[i].rsp);

      // random phases with varied sender idling
      for (int phase = 0; phase < 4; phase++) begin
         idle_pct = (phase == 0) ? 0 : (phase == 2) ? 50 : 12;
         repeat (250) send_request(random_request(phase), 1'b0, unused);
         // drain the FIFOs between phases so later phases start fresh
         for (int t = 0; t < SLOTS; t++)
            send_request(make_req(MODE_REMOVE, 5'(t), 5'($urandom), 1'b0, 1'b0),
                         1'b0, unused);
      end
      start <= 1'b0;

      waited = 0;
      while (pending_rsp.size() != 0 && waited < 1000) begin
         @(posedge clock);
         waited++;
      end
      repeat (10) @(posedge clock);
      if (fail_count == 0 && pending_rsp.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #5ms;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
